>>> hdl/ssp_pkg.sv
// Shared types, constants and helpers for the sphere/box push-out block.
// No dependencies; every module imports this package.
package ssp_pkg;

	localparam int unsigned VEC_W   = 48;
	localparam int unsigned RAD_W   = 32;
	localparam int unsigned SQRT_STEPS = 32;
	localparam int unsigned DIV_STEPS  = 31;

	localparam logic signed [55:0] VMAX = 56'sd140737488355327;
	localparam logic signed [55:0] VMIN = -56'sd140737488355328;

	// one queued request, already split into load and box test
	typedef struct packed {
		logic                       is_box;
		logic                       frozen;
		logic [RAD_W-1:0]           radius;
		logic [2:0][VEC_W-1:0]      a;
		logic [2:0][VEC_W-1:0]      b;
	} ssp_item_t;

	// back-end status seen by the top level
	typedef struct packed {
		logic busy;
		logic done;
	} ssp_stat_t;

	function automatic logic signed [55:0] ext48(input logic signed [47:0] v);
		return $signed({{8{v[47]}}, v});
	endfunction

	// clamp to the 48-bit two's complement range
	function automatic logic signed [47:0] sat48(input logic signed [55:0] v);
		logic signed [47:0] r;
		if (v > VMAX)
			r = VMAX[47:0];
		else if (v < VMIN)
			r = VMIN[47:0];
		else
			r = v[47:0];
		return r;
	endfunction

endpackage

>>> hdl/ssp_if.sv
// Valid/ready channel interfaces for the request and result items.
// No dependencies.
interface ssp_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [47:0] vec_a_x;
	logic [47:0] vec_a_y;
	logic [47:0] vec_a_z;
	logic [47:0] vec_b_x;
	logic [47:0] vec_b_y;
	logic [47:0] vec_b_z;
	logic [31:0] sphere_radius;
	logic        frozen;

	modport source (output valid, req_type, vec_a_x, vec_a_y, vec_a_z,
		vec_b_x, vec_b_y, vec_b_z, sphere_radius, frozen, input ready);
	modport sink (input valid, req_type, vec_a_x, vec_a_y, vec_a_z,
		vec_b_x, vec_b_y, vec_b_z, sphere_radius, frozen, output ready);
endinterface

interface ssp_rsp_if;
	logic        valid;
	logic        ready;
	logic [47:0] pos_x;
	logic [47:0] pos_y;
	logic [47:0] pos_z;
	logic [47:0] vel_x;
	logic [47:0] vel_y;
	logic [47:0] vel_z;
	logic        touched;

	modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		touched, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		touched, output ready);
endinterface

>>> hdl/ssp_front.sv
// Front end: accepts request items, classifies them and queues them (2 deep).
// Depends on ssp_pkg and ssp_req_if.
module ssp_front (
	input  logic              clk,
	input  logic              arst_n,
	ssp_req_if.sink           req,
	output logic              q_valid,
	output ssp_pkg::ssp_item_t q_item,
	input  logic              q_ready
);
	import ssp_pkg::*;

	ssp_item_t  ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	ssp_item_t  in_item;
	logic       push;
	logic       pop;

	// classify the incoming item
	always_comb begin
		in_item.is_box = req.req_type;
		in_item.frozen = req.frozen;
		in_item.radius = req.sphere_radius;
		in_item.a[0]   = req.vec_a_x;
		in_item.a[1]   = req.vec_a_y;
		in_item.a[2]   = req.vec_a_z;
		in_item.b[0]   = req.vec_b_x;
		in_item.b[1]   = req.vec_b_y;
		in_item.b[2]   = req.vec_b_z;
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign pop       = q_valid && q_ready;
	assign q_item    = ent_q[rd_q];

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= in_item;
	end

endmodule

>>> hdl/ssp_isqrt.sv
// Bit-serial integer square root, one result bit per cycle (floor).
// Depends on ssp_pkg.
module ssp_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);
	import ssp_pkg::*;

	logic [63:0] x_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [35:0] trial;
	logic [35:0] tst;

	assign trial = {rem_q, x_q[63:62]};
	assign tst   = {2'd0, root_q, 2'b01};
	assign done  = done_q;
	assign root  = root_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(SQRT_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: two radicand bits per step
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[61:0], 2'b00};
			if (trial >= tst) begin
				rem_q  <= 34'(trial - tst);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= trial[33:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

endmodule

>>> hdl/ssp_div.sv
// Restoring divider, one quotient bit per cycle; quotient is known to fit 31 bits.
// Depends on ssp_pkg.
module ssp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [62:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [30:0] quo
);
	import ssp_pkg::*;

	logic [30:0] num_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [30:0] quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;

	assign trial = {rem_q, num_q[30]};
	assign done  = done_q;
	assign quo   = quo_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath; upper half of the dividend is already below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[62:31];
			num_q <= dividend[30:0];
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[29:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= 32'(trial - {1'b0, dvs_q});
				quo_q <= {quo_q[29:0], 1'b1};
			end else begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[29:0], 1'b0};
			end
		end
	end

endmodule

>>> hdl/ssp_back.sv
// Back end: body state, contact test sequencer with one shared 32x32 multiplier,
// and the result register. Depends on ssp_pkg, ssp_rsp_if, ssp_isqrt, ssp_div.
module ssp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  ssp_pkg::ssp_item_t q_item,
	output logic               q_ready,
	output ssp_pkg::ssp_stat_t stat,
	ssp_rsp_if.source          rsp
);
	import ssp_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_CLAMP  = 4'd1;
	localparam logic [3:0] ST_SQ     = 4'd2;
	localparam logic [3:0] ST_CHK    = 4'd3;
	localparam logic [3:0] ST_PUSHIN = 4'd4;
	localparam logic [3:0] ST_SQRT   = 4'd5;
	localparam logic [3:0] ST_DIVGO  = 4'd6;
	localparam logic [3:0] ST_DIV    = 4'd7;
	localparam logic [3:0] ST_POS    = 4'd8;
	localparam logic [3:0] ST_VN     = 4'd9;
	localparam logic [3:0] ST_VEL    = 4'd10;
	localparam logic [3:0] ST_DONE   = 4'd11;

	logic [3:0]         state_q;
	logic [1:0]         ax_q;
	logic [2:0]         cnt_q;
	logic               touch_q;

	// body state
	logic signed [47:0] pos_q [3];
	logic signed [47:0] vel_q [3];
	logic [31:0]        rad_q;
	logic               frz_q;

	// per-box working registers
	logic signed [47:0] bmin_q [3];
	logic signed [47:0] bmax_q [3];
	logic               dneg_q [3];
	logic [31:0]        m_q [3];
	logic signed [48:0] gap_q [3];
	logic               nside_q [3];
	logic [65:0]        dist2_q;
	logic [63:0]        rr_q;
	logic [31:0]        dist_q;
	logic [30:0]        nmag_q [3];
	logic               nneg_q [3];
	logic signed [52:0] vn_q;
	logic [63:0]        prod_q;
	logic [54:0]        plo_q;

	// result register
	logic               rv_q;
	logic [47:0]        opos_q [3];
	logic [47:0]        ovel_q [3];
	logic               otch_q;

	// combinational
	logic signed [47:0] cl_c [3];
	logic signed [48:0] d_c [3];
	logic [48:0]        dm_c [3];
	logic signed [48:0] glo_c [3];
	logic signed [48:0] ghi_c [3];
	logic signed [48:0] g_c [3];
	logic               ns_c [3];
	logic               hit_c;
	logic [1:0]         k_c;
	logic signed [55:0] pen_in_c;
	logic signed [55:0] newc_c;
	logic               vkill_c;
	logic [31:0]        pen_c;
	logic [47:0]        vmag_c;
	logic [52:0]        vnabs_c;
	logic [49:0]        opa_c;
	logic               mneg_c;
	logic [31:0]        mul_a_c;
	logic [31:0]        mul_b_c;
	logic [80:0]        full_c;
	logic [80:0]        rnd_c;
	logic signed [52:0] sq_c;
	logic signed [52:0] vn_nx_c;
	logic               sq_start;
	logic               sq_done;
	logic [31:0]        sq_root;
	logic               dv_start;
	logic               dv_done;
	logic [30:0]        dv_quo;
	logic [62:0]        dv_num;
	logic               out_free;

	// clamp, offset and face gap on all three axes
	always_comb begin
		hit_c = 1'b1;
		for (int i = 0; i < 3; i++) begin
			cl_c[i] = (pos_q[i] < bmin_q[i]) ? bmin_q[i] : pos_q[i];
			if (cl_c[i] > bmax_q[i])
				cl_c[i] = bmax_q[i];
			d_c[i]   = $signed({pos_q[i][47], pos_q[i]}) - $signed({cl_c[i][47], cl_c[i]});
			dm_c[i]  = d_c[i][48] ? 49'(-d_c[i]) : d_c[i];
			if (dm_c[i] >= {17'd0, rad_q})
				hit_c = 1'b0;
			glo_c[i] = $signed({pos_q[i][47], pos_q[i]}) - $signed({bmin_q[i][47], bmin_q[i]});
			ghi_c[i] = $signed({bmax_q[i][47], bmax_q[i]}) - $signed({pos_q[i][47], pos_q[i]});
			g_c[i]   = (glo_c[i] < ghi_c[i]) ? glo_c[i] : ghi_c[i];
			ns_c[i]  = $signed({pos_q[i][47], pos_q[i], 1'b0}) <
				($signed({{2{bmin_q[i][47]}}, bmin_q[i]}) +
				 $signed({{2{bmax_q[i][47]}}, bmax_q[i]}));
		end
	end

	// inside case: axis of least gap, push through that face
	always_comb begin
		if (gap_q[0] <= gap_q[1] && gap_q[0] <= gap_q[2])
			k_c = 2'd0;
		else if (gap_q[1] <= gap_q[2])
			k_c = 2'd1;
		else
			k_c = 2'd2;
		pen_in_c = $signed({24'd0, rad_q}) + $signed({{7{gap_q[k_c][48]}}, gap_q[k_c]});
		newc_c   = nside_q[k_c] ? (ext48(pos_q[k_c]) - pen_in_c)
		                        : (ext48(pos_q[k_c]) + pen_in_c);
		vkill_c  = nside_q[k_c] ? (vel_q[k_c] > 48'sd0) : (vel_q[k_c] < 48'sd0);
	end

	// shared multiplier operands: squares, then round(a*b/2^30) in two halves
	always_comb begin
		pen_c   = rad_q - dist_q;
		vmag_c  = vel_q[ax_q][47] ? 48'(-vel_q[ax_q]) : vel_q[ax_q];
		vnabs_c = vn_q[52] ? 53'(-vn_q) : vn_q;
		opa_c   = '0;
		mneg_c  = 1'b0;
		case (state_q)
			ST_POS: begin
				opa_c  = {18'd0, pen_c};
				mneg_c = nneg_q[ax_q];
			end
			ST_VN: begin
				opa_c  = {2'd0, vmag_c};
				mneg_c = vel_q[ax_q][47] ^ nneg_q[ax_q];
			end
			ST_VEL: begin
				opa_c  = vnabs_c[49:0];
				mneg_c = vn_q[52] ^ nneg_q[ax_q];
			end
			default: begin
				opa_c  = '0;
				mneg_c = 1'b0;
			end
		endcase
		mul_a_c = '0;
		mul_b_c = '0;
		if (state_q == ST_SQ) begin
			if (cnt_q < 3'd3) begin
				mul_a_c = m_q[cnt_q[1:0]];
				mul_b_c = m_q[cnt_q[1:0]];
			end else if (cnt_q == 3'd3) begin
				mul_a_c = rad_q;
				mul_b_c = rad_q;
			end
		end else begin
			mul_b_c = {1'b0, nmag_q[ax_q]};
			mul_a_c = (cnt_q == 3'd0) ? {8'd0, opa_c[23:0]} : {6'd0, opa_c[49:24]};
		end
		full_c  = {prod_q[56:0], 24'd0} + {26'd0, plo_q};
		rnd_c   = full_c + (81'd1 << 29);
		sq_c    = mneg_c ? -$signed({2'b00, rnd_c[80:30]}) : $signed({2'b00, rnd_c[80:30]});
		vn_nx_c = vn_q + sq_c;
	end

	assign sq_start = (state_q == ST_CHK) && (dist2_q < {2'd0, rr_q}) && (dist2_q != 66'd0);
	assign dv_start = (state_q == ST_DIVGO);
	assign dv_num   = {1'b0, m_q[ax_q], 30'd0} + {32'd0, dist_q[31:1]};

	ssp_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (dist2_q[63:0]),
		.done     (sq_done),
		.root     (sq_root)
	);

	ssp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (dv_num),
		.divisor  (dist_q),
		.done     (dv_done),
		.quo      (dv_quo)
	);

	assign q_ready   = (state_q == ST_IDLE);
	assign out_free  = !rv_q || rsp.ready;
	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_DONE);

	// sequencer and body state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ax_q    <= '0;
			cnt_q   <= '0;
			touch_q <= 1'b0;
			rad_q   <= '0;
			frz_q   <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						touch_q <= 1'b0;
						if (!q_item.is_box) begin
							for (int i = 0; i < 3; i++) begin
								pos_q[i] <= $signed(q_item.a[i]);
								vel_q[i] <= $signed(q_item.b[i]);
							end
							rad_q   <= q_item.radius;
							frz_q   <= q_item.frozen;
							state_q <= ST_DONE;
						end else if (frz_q) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_CLAMP;
						end
					end
				end
				ST_CLAMP: begin
					cnt_q   <= '0;
					state_q <= hit_c ? ST_SQ : ST_DONE;
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd4)
						state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (dist2_q >= {2'd0, rr_q}) begin
						state_q <= ST_DONE;
					end else if (dist2_q == 66'd0) begin
						touch_q <= 1'b1;
						state_q <= ST_PUSHIN;
					end else begin
						touch_q <= 1'b1;
						state_q <= ST_SQRT;
					end
				end
				ST_PUSHIN: begin
					pos_q[k_c] <= sat48(newc_c);
					if (vkill_c)
						vel_q[k_c] <= '0;
					state_q <= ST_DONE;
				end
				ST_SQRT: begin
					ax_q <= '0;
					if (sq_done)
						state_q <= ST_DIVGO;
				end
				ST_DIVGO: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (dv_done) begin
						if (ax_q == 2'd2) begin
							ax_q    <= '0;
							cnt_q   <= '0;
							state_q <= ST_POS;
						end else begin
							ax_q    <= ax_q + 2'd1;
							state_q <= ST_DIVGO;
						end
					end
				end
				ST_POS, ST_VN, ST_VEL: begin
					if (cnt_q != 3'd2) begin
						cnt_q <= cnt_q + 3'd1;
					end else begin
						cnt_q <= '0;
						if (state_q == ST_POS)
							pos_q[ax_q] <= sat48(ext48(pos_q[ax_q]) +
								$signed({{3{sq_c[52]}}, sq_c}));
						if (state_q == ST_VEL)
							vel_q[ax_q] <= sat48(ext48(vel_q[ax_q]) -
								$signed({{3{sq_c[52]}}, sq_c}));
						if (ax_q != 2'd2) begin
							ax_q <= ax_q + 2'd1;
						end else begin
							ax_q <= '0;
							if (state_q == ST_POS)
								state_q <= ST_VN;
							else if (state_q == ST_VN && vn_nx_c < 53'sd0)
								state_q <= ST_VEL;
							else
								state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		prod_q <= {32'd0, mul_a_c} * {32'd0, mul_b_c};
		if (state_q == ST_IDLE && q_valid && q_item.is_box) begin
			for (int i = 0; i < 3; i++) begin
				bmin_q[i] <= $signed(q_item.a[i]);
				bmax_q[i] <= $signed(q_item.b[i]);
			end
		end
		if (state_q == ST_CLAMP) begin
			dist2_q <= '0;
			for (int i = 0; i < 3; i++) begin
				dneg_q[i]  <= d_c[i][48];
				m_q[i]     <= dm_c[i][31:0];
				gap_q[i]   <= g_c[i];
				nside_q[i] <= ns_c[i];
			end
		end
		if (state_q == ST_SQ) begin
			if (cnt_q != 3'd0 && cnt_q != 3'd4)
				dist2_q <= dist2_q + {2'd0, prod_q};
			if (cnt_q == 3'd4)
				rr_q <= prod_q;
		end
		if (state_q == ST_SQRT && sq_done)
			dist_q <= sq_root;
		if (state_q == ST_DIV && dv_done) begin
			nmag_q[ax_q] <= dv_quo;
			nneg_q[ax_q] <= dneg_q[ax_q];
		end
		if (state_q == ST_POS)
			vn_q <= '0;
		if (cnt_q == 3'd1 && (state_q == ST_POS || state_q == ST_VN || state_q == ST_VEL))
			plo_q <= prod_q[54:0];
		if (state_q == ST_VN && cnt_q == 3'd2)
			vn_q <= vn_nx_c;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			rv_q <= 1'b1;
		end else if (rsp.ready) begin
			rv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			for (int i = 0; i < 3; i++) begin
				opos_q[i] <= pos_q[i];
				ovel_q[i] <= vel_q[i];
			end
			otch_q <= touch_q;
		end
	end

	assign rsp.valid   = rv_q;
	assign rsp.pos_x   = opos_q[0];
	assign rsp.pos_y   = opos_q[1];
	assign rsp.pos_z   = opos_q[2];
	assign rsp.vel_x   = ovel_q[0];
	assign rsp.vel_y   = ovel_q[1];
	assign rsp.vel_z   = ovel_q[2];
	assign rsp.touched = otch_q;

endmodule

>>> hdl/sphere_aabb_static_pushout.sv
// Sphere vs. static box push-out, one item at a time behind a 2-deep request queue.
// A load or a frozen body goes straight to the result; a box without contact ends
// after the clamp or the distance check; inside contact pushes through one face;
// outside contact runs the bit-serial square root (32 steps) and three serial
// divisions (31 steps each). arst_n clears body state to zero.
module sphere_aabb_static_pushout (
	input  logic      clk,
	input  logic      arst_n,
	ssp_req_if.sink   req,
	ssp_rsp_if.source rsp
);
	import ssp_pkg::*;

	logic      q_valid;
	logic      q_ready;
	ssp_item_t q_item;
	ssp_stat_t stat;
	logic [2:0] fly_q;

	ssp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_ready (q_ready)
	);

	ssp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_ready (q_ready),
		.stat    (stat),
		.rsp     (rsp)
	);

	// items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fly_q <= '0;
		else
			fly_q <= fly_q + {2'd0, req.valid && req.ready} - {2'd0, rsp.valid && rsp.ready};
	end

	a_fly_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fly_q <= 3'd4)
		else $error("more items in flight than queue, back end and result hold");

	a_fly_empty: assert property (@(posedge clk) disable iff (!arst_n)
		fly_q == 3'd0 |-> !rsp.valid && !stat.busy && !q_valid)
		else $error("result or work present with no item in flight");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_ready |=> stat.busy)
		else $error("back end took an item but did not start");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done && rsp.valid && !rsp.ready |=> stat.done)
		else $error("finished item dropped while the result was still held");

endmodule
